>>> design/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg: shared types and constants for the bitmap store engine
// Request and response beat layouts, opcodes and fixed field widths.
// ----------------------------------------------------------------------------
package bse_pkg;

   localparam int IDX_W  = 10;        // bit_index / range_high width
   localparam int LEN_W  = 11;        // length register and ones count width
   localparam int BASE_W = LEN_W + 1; // running bit offset of a word walk
   localparam int LOW_BITS = 64;      // width of the low word report

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
   localparam logic [LEN_W-1:0] CNT_MAX   = LEN_W'(2047);

   localparam int DEF_MAX_BITS  = 1024;
   localparam int DEF_WORD_BITS = 64;

   localparam logic [2:0] OP_PUT      = 3'd0;
   localparam logic [2:0] OP_TEST     = 3'd1;
   localparam logic [2:0] OP_INVERT   = 3'd2;
   localparam logic [2:0] OP_COUNT    = 3'd3;
   localparam logic [2:0] OP_READ_LOW = 3'd4;

   typedef struct packed {
      logic [2:0]       req_type;
      logic [IDX_W-1:0] bit_index;
      logic [IDX_W-1:0] range_high;
      logic             bit_value;
   } bse_req_type;

   typedef struct packed {
      logic                old_bit;
      logic [LEN_W-1:0]    ones_count;
      logic [LOW_BITS-1:0] low_word;
      logic                range_error;
   } bse_rsp_type;

endpackage

>>> design/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bse_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bitmap_store_engine.sv
// ----------------------------------------------------------------------------
// bitmap_store_engine: word-organized bit vector with put/test/invert/count
// A small sequencer walks one RAM word per cycle through a shared mask,
// popcount and modify unit.
// ----------------------------------------------------------------------------
//
//  channel   ports                          beat moved when
//  -------   -----------------------------  ------------------------------
//  request   start, busy, req_data          start & !busy
//  response  rsp_valid, rsp_data            rsp_valid (one-cycle strobe)
//  csr       csr_valid, csr_ready, csr_data csr_valid & csr_ready
//
// States per beat: put / test / invert go divide, adjust, modify, done,
//   invert repeating modify per word touched. count: divide, modify per
//   word below the length, done. read low word, bad index: divide, done.
//   The walk takes one RAM word per cycle through the single read port.
// Reset: synchronous; a clearing pass then zeroes the store, one word a
//   cycle, all STORE_WORDS words (16 at the defaults), with busy high.
// Stalls: the response cannot be held off; it is shown for one cycle.
// The csr port is always ready; length must be written only while idle; the block does not enforce it.
//
module bitmap_store_engine #(
   parameter int MAX_BITS  = bse_pkg::DEF_MAX_BITS,
   parameter int WORD_BITS = bse_pkg::DEF_WORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  bse_pkg::bse_req_type      req_data,
   output logic                      rsp_valid,
   output bse_pkg::bse_rsp_type      rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bse_pkg::LEN_W-1:0] csr_data
);

   localparam int IDX_W  = bse_pkg::IDX_W;
   localparam int LEN_W  = bse_pkg::LEN_W;
   localparam int BASE_W = bse_pkg::BASE_W;

   localparam int STORE_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int WB_W        = $clog2(WORD_BITS);
   localparam int LOW_W       = (bse_pkg::LOW_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int LEN_CAP     = (MAX_BITS < 2047) ? MAX_BITS : 2047;

   // word index = (idx * RECIP) >> RECIP_SHIFT, low by at most one
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;
   localparam int PROD_W      = IDX_W + RECIP_SHIFT;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_ADJ   = 6'b001000,
      ST_MOD   = 6'b010000,
      ST_DONE  = 6'b100000
   } bse_state_type;

   bse_state_type        state_ff, state_in;
   bse_pkg::bse_req_type req_ff, req_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [ADDR_W-1:0]    word_ff, word_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   logic [IDX_W-1:0]     quot_ff, quot_in;
   logic [WB_W-1:0]      bit_ff, bit_in;
   logic                 old_ff, old_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic                 err_ff, err_in;
   logic [LOW_W*WORD_BITS-1:0] shadow_ff, shadow_in;

   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;

   logic [LEN_W-1:0]     eff_len;
   logic [PROD_W-1:0]    recip_prod;
   logic [BASE_W-1:0]    quot_base;
   logic [BASE_W-1:0]    rem;
   logic [BASE_W-1:0]    next_base;
   logic [WORD_BITS-1:0] inv_mask;
   logic [WORD_BITS-1:0] cnt_mask;
   logic [WORD_BITS-1:0] bit_mask;
   logic [BASE_W-1:0]    pop_sum;
   logic [BASE_W-1:0]    bit_pos [WORD_BITS];

   assign eff_len = (len_ff > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_ff;

   // shared datapath pieces
   assign recip_prod = PROD_W'(req_ff.bit_index) * PROD_W'(RECIP);
   assign quot_base  = BASE_W'(quot_ff) * BASE_W'(WORD_BITS);
   assign rem        = BASE_W'(req_ff.bit_index) - quot_base;
   assign next_base  = base_ff + BASE_W'(WORD_BITS);
   assign bit_mask   = WORD_BITS'(1) << bit_ff;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         bit_pos[b]  = base_ff + BASE_W'(b);
         inv_mask[b] = (bit_pos[b] >= BASE_W'(req_ff.bit_index)) &&
                       (bit_pos[b] <= BASE_W'(req_ff.range_high));
         cnt_mask[b] = bit_pos[b] < BASE_W'(eff_len);
      end
   end

   assign pop_sum = BASE_W'(cnt_ff) + BASE_W'($countones(rd_data & cnt_mask));

   // sequencer
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      word_in  = word_ff;
      base_in  = base_ff;
      quot_in  = quot_ff;
      bit_in   = bit_ff;
      old_in   = old_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      wr_en    = 1'b0;
      wr_data  = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            word_in = word_ff + ADDR_W'(1);
            if (word_ff == ADDR_W'(STORE_WORDS - 1)) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            old_in   = 1'b0;
            cnt_in   = '0;
            err_in   = 1'b0;
            quot_in  = recip_prod[PROD_W-1:RECIP_SHIFT];
            state_in = ST_DONE;
            if (req_ff.req_type == bse_pkg::OP_PUT ||
                req_ff.req_type == bse_pkg::OP_TEST) begin
               if (LEN_W'(req_ff.bit_index) >= eff_len) begin
                  err_in = 1'b1;
               end else begin
                  state_in = ST_ADJ;
               end
            end else if (req_ff.req_type == bse_pkg::OP_INVERT) begin
               if (LEN_W'(req_ff.range_high) >= eff_len ||
                   req_ff.bit_index > req_ff.range_high) begin
                  err_in = 1'b1;
               end else begin
                  state_in = ST_ADJ;
               end
            end else if (req_ff.req_type == bse_pkg::OP_COUNT) begin
               if (eff_len != '0) begin
                  word_in  = '0;
                  base_in  = '0;
                  state_in = ST_MOD;
               end
            end
         end
         ST_ADJ: begin
            // one correction step finishes the reciprocal divide
            if (rem >= BASE_W'(WORD_BITS)) begin
               word_in = ADDR_W'(quot_ff + IDX_W'(1));
               base_in = quot_base + BASE_W'(WORD_BITS);
               bit_in  = WB_W'(rem - BASE_W'(WORD_BITS));
            end else begin
               word_in = ADDR_W'(quot_ff);
               base_in = quot_base;
               bit_in  = WB_W'(rem);
            end
            state_in = ST_MOD;
         end
         ST_MOD: begin
            state_in = ST_DONE;
            case (req_ff.req_type)
               bse_pkg::OP_PUT, bse_pkg::OP_TEST: begin
                  old_in = rd_data[bit_ff];
                  if (req_ff.req_type == bse_pkg::OP_PUT) begin
                     wr_en   = 1'b1;
                     wr_data = req_ff.bit_value ? (rd_data | bit_mask)
                                                : (rd_data & ~bit_mask);
                  end
               end
               bse_pkg::OP_INVERT: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data ^ inv_mask;
                  if (next_base <= BASE_W'(req_ff.range_high)) begin
                     word_in  = word_ff + ADDR_W'(1);
                     base_in  = next_base;
                     state_in = ST_MOD;
                  end
               end
               bse_pkg::OP_COUNT: begin
                  cnt_in = (pop_sum > BASE_W'(bse_pkg::CNT_MAX)) ? bse_pkg::CNT_MAX
                                                                 : LEN_W'(pop_sum);
                  if (next_base < BASE_W'(eff_len)) begin
                     word_in  = word_ff + ADDR_W'(1);
                     base_in  = next_base;
                     state_in = ST_MOD;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // csr write
   assign csr_ready = 1'b1;
   assign len_in    = (csr_valid && csr_ready) ? csr_data : len_ff;

   // mirror of the lowest words for the low word report
   always_comb begin
      shadow_in = shadow_ff;
      for (int k = 0; k < LOW_W; k++) begin
         if (wr_en && word_ff == ADDR_W'(k)) begin
            shadow_in[k*WORD_BITS +: WORD_BITS] = wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         word_ff   <= '0;
         len_ff    <= bse_pkg::LEN_RESET;
         shadow_ff <= '0;
      end else begin
         state_ff  <= state_in;
         word_ff   <= word_in;
         len_ff    <= len_in;
         shadow_ff <= shadow_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      base_ff <= base_in;
      quot_ff <= quot_in;
      bit_ff  <= bit_in;
      old_ff  <= old_in;
      cnt_ff  <= cnt_in;
      err_ff  <= err_in;
   end

   // read address runs one step ahead so data lands in the modify cycle
   bse_ram #(
      .DATA_W (WORD_BITS),
      .DEPTH  (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_addr (word_in),
      .rd_data (rd_data)
   );

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = (state_ff == ST_DONE);
   assign rsp_data.old_bit     = old_ff;
   assign rsp_data.ones_count  = cnt_ff;
   assign rsp_data.low_word    = shadow_ff[bse_pkg::LOW_BITS-1:0];
   assign rsp_data.range_error = err_ff;

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_MOD))
      else $error("store written outside clear or modify");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.range_error) |->
         (!rsp_data.old_bit && rsp_data.ones_count == '0))
      else $error("error response carries data");

   a_no_write_on_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) ##1 err_ff |-> !wr_en)
      else $error("store written after a range error");

endmodule

>>> dv/bitmap_store_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_store_engine_tb: self-checking bench for the bitmap store engine
// Starts with a short list of directed requests at the reset length, then
// runs phases of random requests, each phase under its own length setting.
// A mirror of the store predicts each response beat; the responses are
// checked in order, field by field.
// ----------------------------------------------------------------------------
module bitmap_store_engine_tb;
   import bse_pkg::*;

   localparam int          STORE_WORDS = (DEF_MAX_BITS + DEF_WORD_BITS - 1) / DEF_WORD_BITS;
   localparam logic [2:0]  OP_UNDEF_FIRST = 3'd5;   // types 5..7 do nothing
   localparam logic [2:0]  OP_UNDEF_LAST  = 3'd7;
   localparam int          ITEMS_PER_PHASE = 36;
   localparam int          STALL_LIMIT = 600;       // cycles with no beat at all
   localparam int          SETTLE_CYCLES = 40;      // tail after the last response
   localparam int          MAX_PRINTS = 40;
   localparam int          MAX_GAP = 8;

   // -------------------------------------------------------------------------
   // Store mirror: own copy of the bit store and length register, predicts
   // one response per request, checks responses in order.
   // -------------------------------------------------------------------------
   class bitmap_mirror;
      logic [DEF_WORD_BITS-1:0] mirror_words [STORE_WORDS];
      logic [LEN_W-1:0]         length_reg;
      bse_rsp_type              expected_rsp [$];
      int                       mismatches;
      int                       printed;
      int                       rsp_seen;

      function void clear();
         foreach (mirror_words[w]) mirror_words[w] = '0;
         length_reg = LEN_RESET;
         expected_rsp.delete();
         mismatches = 0;
         printed = 0;
         rsp_seen = 0;
      endfunction

      function void write_length(logic [LEN_W-1:0] value);
         length_reg = value;
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction

      // register values above the store size act as the full store
      function int bits_in_use();
         return (int'(length_reg) > DEF_MAX_BITS) ? DEF_MAX_BITS : int'(length_reg);
      endfunction

      function logic bit_at(int i);
         return mirror_words[i / DEF_WORD_BITS][i % DEF_WORD_BITS];
      endfunction

      function void set_bit(int i, logic v);
         mirror_words[i / DEF_WORD_BITS][i % DEF_WORD_BITS] = v;
      endfunction

      function void note_request(bse_req_type r);
         bse_rsp_type e;
         int len, idx, hi, ones;
         len = bits_in_use();
         idx = int'(r.bit_index);
         hi = int'(r.range_high);
         e = '0;
         case (r.req_type)
            OP_PUT, OP_TEST: begin
               if (idx >= len) begin
                  e.range_error = 1'b1;
               end else begin
                  e.old_bit = bit_at(idx);
                  if (r.req_type == OP_PUT) set_bit(idx, r.bit_value);
               end
            end
            OP_INVERT: begin
               if (hi >= len || idx > hi) begin
                  e.range_error = 1'b1;
               end else begin
                  for (int i = idx; i <= hi; i++) set_bit(i, ~bit_at(i));
               end
            end
            OP_COUNT: begin
               // bits above the length are kept but never counted
               ones = 0;
               for (int i = 0; i < len; i++) ones += bit_at(i);
               if (ones > int'(CNT_MAX)) ones = int'(CNT_MAX);
               e.ones_count = LEN_W'(ones);
            end
            default: ;
         endcase
         // low word is reported after every request, bits beyond length too
         for (int i = 0; i < LOW_BITS; i++) e.low_word[i] = bit_at(i);
         expected_rsp.push_back(e);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (printed < MAX_PRINTS) begin
            printed++;
            $display("[%0t] response %0d: %s", $realtime, rsp_seen, what);
         end
      endtask

      task check_response(bse_rsp_type got);
         bse_rsp_type e;
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", got));
            return;
         end
         e = expected_rsp.pop_front();
         if (got.old_bit !== e.old_bit)
            report_mismatch($sformatf("old_bit %b, want %b", got.old_bit, e.old_bit));
         if (got.ones_count !== e.ones_count)
            report_mismatch($sformatf("ones_count %0d, want %0d",
                                      got.ones_count, e.ones_count));
         if (got.low_word !== e.low_word)
            report_mismatch($sformatf("low_word %h, want %h", got.low_word, e.low_word));
         if (got.range_error !== e.range_error)
            report_mismatch($sformatf("range_error %b, want %b",
                                      got.range_error, e.range_error));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT hookup. All inputs start at known values.
   // -------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   bse_req_type      req_data = '0;
   logic             rsp_valid;
   bse_rsp_type      rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_data = '0;

   bitmap_mirror     store_mirror;
   int               cur_len = DEF_MAX_BITS;   // length as the stimulus sees it
   int               stall_cycles = 0;

   always #5 clock = ~clock;

   bitmap_store_engine dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // -------------------------------------------------------------------------
   // Monitor. Everything here reads pre-edge values: the bench and the DUT
   // both update with nonblocking assignments, so sampling right at the edge
   // sees exactly what the DUT saw. The response strobe is checked before
   // the new request is noted; a beat out can never belong to the beat in.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) store_mirror.check_response(rsp_data);
         if (start && !busy) store_mirror.note_request(req_data);
         if (csr_valid && csr_ready) store_mirror.write_length(csr_data);
      end
   end

   // Watchdog: any beat on any channel restarts the count. The longest
   // honest quiet stretch is a full-store walk plus a max sender gap plus
   // the clearing pass after reset, well under the limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   function automatic bse_req_type make_req(logic [2:0] op, int idx, int hi, logic val);
      bse_req_type r;
      r.req_type = op;
      r.bit_index = IDX_W'(idx);
      r.range_high = IDX_W'(hi);
      r.bit_value = val;
      return r;
   endfunction

   // One request beat. With gap 0, start stays high straight into the next
   // beat; it is never dropped and raised within one step.
   task automatic drive_req(bse_req_type r, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait for every predicted response and an idle engine.
   // At least one edge passes first so the monitor has noted the last beat.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (store_mirror.outstanding() != 0 || busy);
   endtask

   // Length writes only go in while the engine is idle.
   task automatic set_length(int value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= LEN_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_len = value;
   endtask

   // Random request. Mostly indexes inside the length in use so that most
   // beats really touch the store; the rest is any value the fields allow.
   function automatic bse_req_type random_req(int eff);
      bse_req_type r;
      int roll, lo, span;
      roll = $urandom_range(0, 99);
      if (roll < 24)      r.req_type = OP_PUT;
      else if (roll < 44) r.req_type = OP_TEST;
      else if (roll < 66) r.req_type = OP_INVERT;
      else if (roll < 78) r.req_type = OP_COUNT;
      else if (roll < 90) r.req_type = OP_READ_LOW;
      else                r.req_type = 3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
      r.bit_index = IDX_W'($urandom_range(0, DEF_MAX_BITS - 1));
      r.range_high = IDX_W'($urandom_range(0, DEF_MAX_BITS - 1));
      r.bit_value = 1'($urandom_range(0, 1));
      if (eff > 0 && $urandom_range(0, 9) < 8) begin
         lo = $urandom_range(0, eff - 1);
         // short spans mostly, now and then up to the top
         span = ($urandom_range(0, 3) == 0) ? eff : $urandom_range(0, 80);
         r.bit_index = IDX_W'(lo);
         r.range_high = IDX_W'((lo + span >= eff) ? eff - 1 : lo + span);
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int phase_len [$];
      int eff;
      store_mirror = new();
      store_mirror.clear();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, at the reset length: word edges, top bit, full-store
      // invert, error on low above high, the undefined types.
      drive_req(make_req(OP_TEST, 0, 0, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_READ_LOW, 0, 0, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_COUNT, 0, 0, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_PUT, 0, 0, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_PUT, 63, 0, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_PUT, 64, 0, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_PUT, 1023, 0, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_PUT, 1023, 0, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_TEST, 64, 1023, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_COUNT, 0, 0, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_INVERT, 0, 1023, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_COUNT, 1023, 1023, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_TEST, 1023, 0, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_INVERT, 1000, 1000, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_INVERT, 10, 9, 1'b0), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_INVERT, 0, 0, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_PUT, 1023, 1023, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_UNDEF_FIRST, 1023, 1023, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(3'd6, 1023, 1023, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_UNDEF_LAST, 1023, 1023, 1'b1), $urandom_range(0, MAX_GAP));
      drive_req(make_req(OP_READ_LOW, 1023, 1023, 1'b1), $urandom_range(0, MAX_GAP));

      // Length settings per phase: zero, one, all ones in the register,
      // word edges, the top, then random ones. Lowering the length after
      // the full-store invert leaves bits above it set.
      phase_len = '{0, 1, 2047, 64, 65, 1023, 1024};
      phase_len.push_back($urandom_range(1, DEF_MAX_BITS));
      phase_len.push_back($urandom_range(1, 200));
      phase_len.push_back($urandom_range(DEF_MAX_BITS + 1, 2047));
      phase_len.push_back($urandom_range(1, DEF_MAX_BITS));

      foreach (phase_len[p]) begin
         set_length(phase_len[p]);
         eff = (cur_len > DEF_MAX_BITS) ? DEF_MAX_BITS : cur_len;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // now and then hold off until the engine has answered everything
            if ($urandom_range(0, 29) == 0) wait_drained();
            drive_req(random_req(eff), $urandom_range(0, MAX_GAP));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (store_mirror.mismatches == 0 && store_mirror.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
design/bse_pkg.sv
design/bse_ram.sv
design/bitmap_store_engine.sv
dv/bitmap_store_engine_tb.sv
